[rtl/ccs_pkg.sv]
// shared types, constants and the arctangent table of the collision cone heading selector
// no dependencies; every other file of the block imports it
package ccs_pkg;

   localparam int MAX_CONTACTS  = 16;
   localparam int SLOT_IDX_W    = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
   localparam int CORDIC_STEPS  = 20;
   localparam int CORDIC_IDX_W  = $clog2(CORDIC_STEPS);
   localparam int ANG_W         = 36;
   localparam longint ANG_DEG   = 6553600;
   localparam logic signed [ANG_W-1:0] ANG_2   = ANG_W'(2 * ANG_DEG);
   localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * ANG_DEG);
   localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * ANG_DEG);
   localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * ANG_DEG);
   localparam logic [15:0] HEADING_MOD = 16'd36000;

   localparam logic [1:0] CMD_NAV     = 2'd0;
   localparam logic [1:0] CMD_CONTACT = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_SPARE   = 2'd3;

   localparam logic [1:0] REG_SAFETY_RADIUS = 2'd0;
   localparam logic [1:0] REG_ACTIVATION    = 2'd1;
   localparam logic [1:0] REG_DES_HEADING   = 2'd2;
   localparam logic [1:0] REG_DES_SPEED     = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        nav_hdg;
   } req_type;

   typedef struct packed {
      logic        collision_detected;
      logic [15:0] avoidance_heading;
      logic [15:0] avoidance_speed;
      logic [31:0] near_range;
   } rsp_type;

   typedef struct packed {
      logic [23:0] safety_radius;
      logic [23:0] activation_distance;
      logic [15:0] desired_heading;
      logic [15:0] desired_speed;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] own_x;
      logic signed [31:0] own_y;
      logic [15:0]        own_heading;
   } own_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } contact_type;

   // atan(2^-i) in 1/65536 centi-degree
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CORDIC_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 36'sd294912000;
         5'd1:  v = 36'sd174096719;
         5'd2:  v = 36'sd91987925;
         5'd3:  v = 36'sd46694507;
         5'd4:  v = 36'sd23437865;
         5'd5:  v = 36'sd11730358;
         5'd6:  v = 36'sd5866610;
         5'd7:  v = 36'sd2933484;
         5'd8:  v = 36'sd1466764;
         5'd9:  v = 36'sd733385;
         5'd10: v = 36'sd366693;
         5'd11: v = 36'sd183346;
         5'd12: v = 36'sd91673;
         5'd13: v = 36'sd45837;
         5'd14: v = 36'sd22918;
         5'd15: v = 36'sd11459;
         5'd16: v = 36'sd5730;
         5'd17: v = 36'sd2865;
         5'd18: v = 36'sd1432;
         5'd19: v = 36'sd716;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/collision_cone_heading_select.sv]
// Collision cone heading selector. Navigation updates and contact reports only write the own
// state or the contact table. A compute request walks all MAX_CONTACTS slots (an empty slot
// in B_SCAN alone, a valid one through B_SCAN, B_SQX, B_SQY and B_CMP, using a shared 32x32
// multiplier), squares the two range limits, runs a bit-serial square root of 32 steps for the
// range and, on the cone path, a second one, then two vectoring CORDIC passes of up to about
// 30 normalize steps plus 20 rotations each, and the heading arithmetic of B_FIN1 to B_FIN3.
// New requests are stalled while a compute is queued or in flight, until its result has been taken.
// Depends on ccs_pkg, ccs_front, ccs_queue, ccs_cordic and ccs_back.
module collision_cone_heading_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ccs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccs_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ccs_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   wr_en;
   logic                   q_empty, q_push, q_pop, back_busy;
   own_type                q_push_data, q_pop_data;
   logic [SLOT_IDX_W-1:0]  rd_idx;
   contact_type            rd_contact;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SAFETY_RADIUS: cfg_in.safety_radius       = pwdata[23:0];
            REG_ACTIVATION:    cfg_in.activation_distance = pwdata[23:0];
            REG_DES_HEADING:   cfg_in.desired_heading     = pwdata[15:0];
            REG_DES_SPEED:     cfg_in.desired_speed       = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SAFETY_RADIUS: prdata = 32'(cfg_ff.safety_radius);
         REG_ACTIVATION:    prdata = 32'(cfg_ff.activation_distance);
         REG_DES_HEADING:   prdata = 32'(cfg_ff.desired_heading);
         REG_DES_SPEED:     prdata = 32'(cfg_ff.desired_speed);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.safety_radius       <= 24'd6400;
         cfg_ff.activation_distance <= 24'd12800;
         cfg_ff.desired_heading     <= 16'd0;
         cfg_ff.desired_speed       <= 16'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .q_empty     (q_empty),
      .back_busy   (back_busy),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .rd_idx      (rd_idx),
      .rd_contact  (rd_contact)
   );

   ccs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   ccs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .busy       (back_busy),
      .rd_idx     (rd_idx),
      .rd_contact (rd_contact),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/ccs_front.sv]
// front end: takes requests, keeps own state and the contact table, queues compute requests
// depends on ccs_pkg
module ccs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  ccs_pkg::req_type                   req_data,
   output logic                               req_stall,
   input  logic                               q_empty,
   input  logic                               back_busy,
   output logic                               q_push,
   output ccs_pkg::own_type                   q_push_data,
   input  logic [ccs_pkg::SLOT_IDX_W-1:0]     rd_idx,
   output ccs_pkg::contact_type               rd_contact
);
   import ccs_pkg::*;

   own_type                 own_ff, own_in;
   logic [MAX_CONTACTS-1:0] valid_ff, valid_in;
   logic signed [31:0]      cx_ff [MAX_CONTACTS];
   logic signed [31:0]      cy_ff [MAX_CONTACTS];
   logic                    accept;
   logic                    slot_ok;
   logic [SLOT_IDX_W-1:0]   widx;

   // one compute in flight at a time, so the table is stable while the back end reads it
   assign req_stall = !q_empty || back_busy;
   assign accept    = req_valid && !req_stall;
   assign slot_ok   = 32'(req_data.slot) < MAX_CONTACTS;
   assign widx      = SLOT_IDX_W'(req_data.slot);

   assign q_push      = accept && (req_data.cmd == CMD_COMPUTE);
   assign q_push_data = own_ff;

   always_comb begin
      own_in   = own_ff;
      valid_in = valid_ff;
      if (accept && req_data.cmd == CMD_NAV) begin
         own_in.own_x       = req_data.pos_x;
         own_in.own_y       = req_data.pos_y;
         own_in.own_heading = req_data.nav_hdg;
      end
      if (accept && req_data.cmd == CMD_CONTACT && slot_ok) begin
         valid_in[widx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= '0;
         valid_ff <= '0;
      end else begin
         own_ff   <= own_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_CONTACT && slot_ok) begin
         cx_ff[widx] <= req_data.pos_x;
         cy_ff[widx] <= req_data.pos_y;
      end
   end

   assign rd_contact.valid = valid_ff[rd_idx];
   assign rd_contact.x     = cx_ff[rd_idx];
   assign rd_contact.y     = cy_ff[rd_idx];

endmodule

[rtl/ccs_queue.sv]
// two-entry queue of compute requests with their own-state snapshot
// depends on ccs_pkg
module ccs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ccs_pkg::own_type  push_data,
   input  logic              pop,
   output logic              empty,
   output ccs_pkg::own_type  pop_data
);
   import ccs_pkg::*;

   own_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && (count_ff != 2'd2);
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ccs_cordic.sv]
// vectoring cordic: first-quadrant atan2 of two magnitudes, one rotation per cycle
// depends on ccs_pkg (angle constants and arctangent table)
module ccs_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         ny,
   input  logic [31:0]                         nx,
   output logic                                done,
   output logic signed [ccs_pkg::ANG_W-1:0]    z
);
   import ccs_pkg::*;

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_NORM = 4'b0010,
      C_ITER = 4'b0100,
      C_DONE = 4'b1000
   } cst_type;

   cst_type                   st_ff, st_in;
   logic [31:0]               ny_ff, ny_in, nx_ff, nx_in;
   logic signed [ANG_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CORDIC_IDX_W-1:0]   i_ff, i_in;
   logic [31:0]               mag;
   logic signed [ANG_W-1:0]   sx, sy;

   assign mag = ny_ff | nx_ff;
   assign sx  = y_ff >>> i_ff;
   assign sy  = x_ff >>> i_ff;

   always_comb begin
      st_in = st_ff;
      ny_in = ny_ff;
      nx_in = nx_ff;
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      i_in  = i_ff;
      case (st_ff)
         C_IDLE, C_DONE: begin
            st_in = C_IDLE;
            if (start) begin
               ny_in = ny;
               nx_in = nx;
               z_in  = '0;
               st_in = (ny == 32'd0 && nx == 32'd0) ? C_DONE : C_NORM;
            end
         end
         C_NORM: begin
            // bring the larger magnitude into [2^30, 2^31)
            if (mag[31]) begin
               ny_in = ny_ff >> 1;
               nx_in = nx_ff >> 1;
            end else if (!mag[30]) begin
               ny_in = ny_ff << 1;
               nx_in = nx_ff << 1;
            end else begin
               x_in  = ANG_W'($signed({1'b0, nx_ff}));
               y_in  = ANG_W'($signed({1'b0, ny_ff}));
               i_in  = '0;
               st_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!y_ff[ANG_W-1]) begin
               x_in = x_ff + sx;
               y_in = y_ff - sy;
               z_in = z_ff + atan_entry(i_ff);
            end else begin
               x_in = x_ff - sx;
               y_in = y_ff + sy;
               z_in = z_ff - atan_entry(i_ff);
            end
            i_in = i_ff + 1'b1;
            if (i_ff == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
               st_in = C_DONE;
            end
         end
         default: st_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= C_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      ny_ff <= ny_in;
      nx_ff <= nx_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      i_ff  <= i_in;
   end

   assign done = (st_ff == C_DONE);
   assign z    = z_ff[ANG_W-1] ? '0 : ((z_ff > ANG_90) ? ANG_90 : z_ff);

endmodule

[rtl/ccs_back.sv]
// back end: nearest-contact scan, square roots and heading arithmetic, result register
// depends on ccs_pkg and ccs_cordic
module ccs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ccs_pkg::cfg_type                  cfg,
   input  logic                              q_empty,
   input  ccs_pkg::own_type                  q_data,
   output logic                              q_pop,
   output logic                              busy,
   output logic [ccs_pkg::SLOT_IDX_W-1:0]    rd_idx,
   input  ccs_pkg::contact_type              rd_contact,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ccs_pkg::rsp_type                  rsp_data
);
   import ccs_pkg::*;

   typedef enum logic [15:0] {
      B_IDLE   = 16'b0000000000000001,
      B_SCAN   = 16'b0000000000000010,
      B_SQX    = 16'b0000000000000100,
      B_SQY    = 16'b0000000000001000,
      B_CMP    = 16'b0000000000010000,
      B_SQR    = 16'b0000000000100000,
      B_SQA    = 16'b0000000001000000,
      B_DECIDE = 16'b0000000010000000,
      B_ROOTD  = 16'b0000000100000000,
      B_ROOTC  = 16'b0000001000000000,
      B_AT1    = 16'b0000010000000000,
      B_AT2    = 16'b0000100000000000,
      B_FIN1   = 16'b0001000000000000,
      B_FIN2   = 16'b0010000000000000,
      B_FIN3   = 16'b0100000000000000,
      B_OUT    = 16'b1000000000000000
   } bst_type;

   bst_type                 st_ff, st_in;
   own_type                 own_ff, own_in;
   logic [SLOT_IDX_W-1:0]   i_ff, i_in;
   logic                    found_ff, found_in, bovf_ff, bovf_in;
   logic [63:0]             bs_ff, bs_in;
   logic [31:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic                    dxn_ff, dxn_in, dyn_ff, dyn_in;
   logic [31:0]             bax_ff, bax_in, bay_ff, bay_in;
   logic                    bdxn_ff, bdxn_in, bdyn_ff, bdyn_in;
   logic [63:0]             sqx_ff, sqx_in, r2_ff, r2_in;
   logic                    within_ff, within_in;
   logic [63:0]             sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [31:0]             dist_ff, dist_in, root_c_ff, root_c_in;
   logic signed [ANG_W-1:0] q_ff, q_in, as_ff, as_in, h_ff, h_in;
   logic [15:0]             heading_ff, heading_in;
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mul_ff;
   logic signed [32:0]      dx, dy;
   logic [64:0]             sum;
   logic                    last;
   logic [63:0]             trial, n_step, r_step;
   logic                    ge;
   logic                    at_start, at_done;
   logic [31:0]             at_ny, at_nx;
   logic signed [ANG_W-1:0] at_z, theta;
   logic [ANG_W-1:0]        rnd;
   logic [15:0]             cd;

   function automatic logic [15:0] heading_wrap(input logic [15:0] v);
      return (v >= HEADING_MOD) ? v - HEADING_MOD : v;
   endfunction

   assign busy   = (st_ff != B_IDLE);
   assign q_pop  = (st_ff == B_IDLE) && !q_empty;
   assign rd_idx = i_ff;
   assign last   = (i_ff == SLOT_IDX_W'(MAX_CONTACTS - 1));

   assign dx  = $signed({rd_contact.x[31], rd_contact.x}) - $signed({own_ff.own_x[31], own_ff.own_x});
   assign dy  = $signed({rd_contact.y[31], rd_contact.y}) - $signed({own_ff.own_y[31], own_ff.own_y});
   assign sum = {1'b0, sqx_ff} + {1'b0, mul_ff};

   // one bit-pair per cycle of the integer square root
   assign trial  = sq_r_ff + sq_bit_ff;
   assign ge     = (sq_n_ff >= trial);
   assign n_step = ge ? sq_n_ff - trial : sq_n_ff;
   assign r_step = ge ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;

   assign at_start = (st_ff == B_ROOTC && sq_bit_ff[0]) || (st_ff == B_AT1 && at_done);
   assign at_ny    = (st_ff == B_ROOTC) ? bay_ff : 32'(cfg.safety_radius);
   assign at_nx    = (st_ff == B_ROOTC) ? bax_ff : root_c_ff;

   assign theta = !bdxn_ff ? (bdyn_ff ? -q_ff : q_ff)
                           : (bdyn_ff ? q_ff - ANG_180 : ANG_180 - q_ff);
   assign rnd   = h_ff + ANG_W'(32768);
   assign cd    = rnd[31:16];

   always_comb begin
      case (st_ff)
         B_SQX:   begin mul_a = ax_ff; mul_b = ax_ff; end
         B_SQY:   begin mul_a = ay_ff; mul_b = ay_ff; end
         B_SQR:   begin
            mul_a = 32'(cfg.safety_radius);
            mul_b = 32'(cfg.safety_radius);
         end
         B_SQA:   begin
            mul_a = 32'(cfg.activation_distance);
            mul_b = 32'(cfg.activation_distance);
         end
         default: begin mul_a = ax_ff; mul_b = ax_ff; end
      endcase
   end

   always_comb begin
      st_in      = st_ff;
      own_in     = own_ff;
      i_in       = i_ff;
      found_in   = found_ff;
      bovf_in    = bovf_ff;
      bs_in      = bs_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      dxn_in     = dxn_ff;
      dyn_in     = dyn_ff;
      bax_in     = bax_ff;
      bay_in     = bay_ff;
      bdxn_in    = bdxn_ff;
      bdyn_in    = bdyn_ff;
      sqx_in     = sqx_ff;
      r2_in      = r2_ff;
      within_in  = within_ff;
      sq_n_in    = sq_n_ff;
      sq_r_in    = sq_r_ff;
      sq_bit_in  = sq_bit_ff;
      dist_in    = dist_ff;
      root_c_in  = root_c_ff;
      q_in       = q_ff;
      as_in      = as_ff;
      h_in       = h_ff;
      heading_in = heading_ff;
      case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               own_in   = q_data;
               i_in     = '0;
               found_in = 1'b0;
               bovf_in  = 1'b0;
               bs_in    = '0;
               st_in    = B_SCAN;
            end
         end
         B_SCAN: begin
            if (rd_contact.valid) begin
               ax_in  = dx[32] ? 32'(-dx) : dx[31:0];
               ay_in  = dy[32] ? 32'(-dy) : dy[31:0];
               dxn_in = dx[32];
               dyn_in = dy[32];
               st_in  = B_SQX;
            end else if (last) begin
               st_in = B_SQR;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         B_SQX: st_in = B_SQY;
         B_SQY: begin
            sqx_in = mul_ff;
            st_in  = B_CMP;
         end
         B_CMP: begin
            // an overflowed range only wins when nothing else was found
            if (!found_ff || (!sum[64] && (bovf_ff || sum[63:0] < bs_ff))) begin
               found_in = 1'b1;
               bovf_in  = sum[64];
               bs_in    = sum[63:0];
               bax_in   = ax_ff;
               bay_in   = ay_ff;
               bdxn_in  = dxn_ff;
               bdyn_in  = dyn_ff;
            end
            if (last) begin
               st_in = B_SQR;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = B_SCAN;
            end
         end
         B_SQR: st_in = B_SQA;
         B_SQA: begin
            r2_in = mul_ff;
            st_in = B_DECIDE;
         end
         B_DECIDE: begin
            within_in = found_ff && !bovf_ff && (bs_ff < mul_ff);
            sq_n_in   = bs_ff;
            sq_r_in   = '0;
            sq_bit_in = 64'd1 << 62;
            st_in     = B_ROOTD;
         end
         B_ROOTD: begin
            sq_n_in   = n_step;
            sq_r_in   = r_step;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               dist_in = (found_ff && !bovf_ff) ? r_step[31:0] : 32'hFFFF_FFFF;
               if (!within_ff) begin
                  heading_in = heading_wrap(cfg.desired_heading);
                  st_in      = B_OUT;
               end else if (bs_ff > r2_ff) begin
                  sq_n_in   = bs_ff - r2_ff;
                  sq_r_in   = '0;
                  sq_bit_in = 64'd1 << 62;
                  st_in     = B_ROOTC;
               end else begin
                  heading_in = heading_wrap(own_ff.own_heading);
                  st_in      = B_OUT;
               end
            end
         end
         B_ROOTC: begin
            sq_n_in   = n_step;
            sq_r_in   = r_step;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               root_c_in = r_step[31:0];
               st_in     = B_AT1;
            end
         end
         B_AT1: begin
            if (at_done) begin
               q_in  = at_z;
               st_in = B_AT2;
            end
         end
         B_AT2: begin
            if (at_done) begin
               as_in = at_z;
               st_in = B_FIN1;
            end
         end
         B_FIN1: begin
            // bearing from north plus the cone half-angle plus the margin
            h_in  = ANG_90 - theta + as_ff + ANG_2;
            st_in = B_FIN2;
         end
         B_FIN2: begin
            if (h_ff[ANG_W-1]) begin
               h_in = h_ff + ANG_360;
            end else if (h_ff >= ANG_360) begin
               h_in = h_ff - ANG_360;
            end
            st_in = B_FIN3;
         end
         B_FIN3: begin
            heading_in = (cd >= HEADING_MOD) ? 16'd0 : cd;
            st_in      = B_OUT;
         end
         B_OUT: begin
            if (!rsp_stall) begin
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff     <= mul_a * mul_b;
      own_ff     <= own_in;
      i_ff       <= i_in;
      found_ff   <= found_in;
      bovf_ff    <= bovf_in;
      bs_ff      <= bs_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      dxn_ff     <= dxn_in;
      dyn_ff     <= dyn_in;
      bax_ff     <= bax_in;
      bay_ff     <= bay_in;
      bdxn_ff    <= bdxn_in;
      bdyn_ff    <= bdyn_in;
      sqx_ff     <= sqx_in;
      r2_ff      <= r2_in;
      within_ff  <= within_in;
      sq_n_ff    <= sq_n_in;
      sq_r_ff    <= sq_r_in;
      sq_bit_ff  <= sq_bit_in;
      dist_ff    <= dist_in;
      root_c_ff  <= root_c_in;
      q_ff       <= q_in;
      as_ff      <= as_in;
      h_ff       <= h_in;
      heading_ff <= heading_in;
   end

   ccs_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (at_start),
      .ny    (at_ny),
      .nx    (at_nx),
      .done  (at_done),
      .z     (at_z)
   );

   assign rsp_valid                   = (st_ff == B_OUT);
   assign rsp_data.collision_detected = within_ff;
   assign rsp_data.avoidance_heading  = heading_ff;
   assign rsp_data.avoidance_speed    = cfg.desired_speed;
   assign rsp_data.near_range         = dist_ff;

   a_collision_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && within_ff |-> dist_ff < 32'(cfg.activation_distance))
      else $error("collision flagged beyond activation distance");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> heading_ff < HEADING_MOD)
      else $error("heading out of range");

   a_pop_starts_scan: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff == B_SCAN)
      else $error("popped request did not start a scan");

endmodule

[tb/testbench.sv]
// self-checking testbench of collision_cone_heading_select: a scoreboard class predicts every
// compute result bit for bit, while plain tasks drive requests and csr writes
// depends on ccs_pkg and the collision_cone_heading_select top level
module testbench;
   import ccs_pkg::*;

   localparam int  WATCHDOG_LIMIT = 6000;
   localparam int  PHASE_ITEMS    = 250;
   localparam longint DEG_UNIT    = 6553600;

   class avoid_scoreboard;
      logic [23:0]        safety_radius;
      logic [23:0]        activation_distance;
      logic [15:0]        desired_heading;
      logic [15:0]        desired_speed;
      logic signed [31:0] own_x, own_y;
      logic [15:0]        own_heading;
      bit                 slot_used[MAX_CONTACTS];
      logic signed [31:0] slot_x[MAX_CONTACTS];
      logic signed [31:0] slot_y[MAX_CONTACTS];
      rsp_type            exp_q[$];
      int                 errors;
      int                 results;
      int                 collisions;
      int                 cone_hits;

      function new();
         safety_radius = 24'd6400;
         activation_distance = 24'd12800;
         desired_heading = 16'd0;
         desired_speed = 16'd512;
         own_x = '0;
         own_y = '0;
         own_heading = '0;
         foreach (slot_used[i]) slot_used[i] = 0;
         errors = 0;
         results = 0;
         collisions = 0;
         cone_hits = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_SAFETY_RADIUS: safety_radius = val[23:0];
            REG_ACTIVATION:    activation_distance = val[23:0];
            REG_DES_HEADING:   desired_heading = val[15:0];
            REG_DES_SPEED:     desired_speed = val[15:0];
            default: ;
         endcase
      endfunction

      function automatic bit [63:0] int_sqrt(bit [63:0] n);
         bit [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // first-quadrant arctangent by vectoring rotations, 1/65536 centi-degree
      function automatic longint quad_angle(bit [63:0] ny, bit [63:0] nx);
         longint x, y, z, sx, sy;
         longint rot[CORDIC_STEPS] = '{294912000, 174096719, 91987925, 46694507, 23437865,
            11730358, 5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
            22918, 11459, 5730, 2865, 1432, 716};
         if (ny == 0 && nx == 0) return 0;
         while ((ny | nx) >= (64'd1 << 31)) begin
            ny = ny >> 1;
            nx = nx >> 1;
         end
         while ((ny | nx) < (64'd1 << 30)) begin
            ny = ny << 1;
            nx = nx << 1;
         end
         x = longint'(nx);
         y = longint'(ny);
         z = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0) begin
               x = x + sx; y = y - sy; z = z + rot[i];
            end else begin
               x = x - sx; y = y + sy; z = z - rot[i];
            end
         end
         if (z < 0) z = 0;
         if (z > 90 * DEG_UNIT) z = 90 * DEG_UNIT;
         return z;
      endfunction

      function automatic logic [15:0] cone_edge(longint dx, longint dy, bit [63:0] s,
                                                bit [63:0] r2);
         bit [63:0] ax, ay, cd;
         longint q, theta, h, full;
         full = 360 * DEG_UNIT;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         q = quad_angle(ay, ax);
         if (dx >= 0) theta = (dy >= 0) ? q : -q;
         else theta = (dy >= 0) ? (180 * DEG_UNIT - q) : (q - 180 * DEG_UNIT);
         h = 90 * DEG_UNIT - theta;
         h = h + quad_angle(64'(safety_radius), int_sqrt(s - r2));
         h = h + 2 * DEG_UNIT;
         h = h % full;
         if (h < 0) h = h + full;
         cd = (64'(h) + 64'd32768) >> 16;
         if (cd >= 36000) cd = cd - 36000;
         return cd[15:0];
      endfunction

      function void note_request(req_type r);
         bit found, best_ovf, ovf, in_range;
         bit [63:0] best_s, ax, ay, a, s, r2, a2, range_val;
         longint best_dx, best_dy, dx, dy;
         rsp_type p;
         case (r.cmd)
            CMD_NAV: begin
               own_x = r.pos_x;
               own_y = r.pos_y;
               own_heading = r.nav_hdg;
            end
            CMD_CONTACT: begin
               slot_used[r.slot] = 1;
               slot_x[r.slot] = r.pos_x;
               slot_y[r.slot] = r.pos_y;
            end
            CMD_COMPUTE: begin
               found = 0;
               best_ovf = 0;
               best_s = 0;
               best_dx = 0;
               best_dy = 0;
               for (int i = 0; i < MAX_CONTACTS; i++) begin
                  if (slot_used[i]) begin
                     dx = longint'(slot_x[i]) - longint'(own_x);
                     dy = longint'(slot_y[i]) - longint'(own_y);
                     ax = dx < 0 ? -dx : dx;
                     ay = dy < 0 ? -dy : dy;
                     a = ax * ax;
                     s = a + ay * ay;
                     ovf = s < a;
                     if (!found || (!ovf && (best_ovf || s < best_s))) begin
                        found = 1;
                        best_ovf = ovf;
                        best_s = s;
                        best_dx = dx;
                        best_dy = dy;
                     end
                  end
               end
               range_val = (!found || best_ovf) ? 64'hFFFF_FFFF : int_sqrt(best_s);
               r2 = 64'(safety_radius) * 64'(safety_radius);
               a2 = 64'(activation_distance) * 64'(activation_distance);
               in_range = found && !best_ovf && best_s < a2;
               if (!in_range) p.avoidance_heading = desired_heading % HEADING_MOD;
               else if (best_s > r2) begin
                  p.avoidance_heading = cone_edge(best_dx, best_dy, best_s, r2);
                  cone_hits++;
               end else p.avoidance_heading = own_heading % HEADING_MOD;
               p.collision_detected = in_range;
               p.avoidance_speed = desired_speed;
               p.near_range = range_val[31:0];
               if (in_range) collisions++;
               exp_q.push_back(p);
            end
            default: ;
         endcase
      endfunction

      function void field_cmp(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_type act);
         rsp_type e;
         if (exp_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, act);
            errors++;
            return;
         end
         e = exp_q.pop_front();
         results++;
         field_cmp("collision_detected", 32'(e.collision_detected),
                   32'(act.collision_detected));
         field_cmp("avoidance_heading", 32'(e.avoidance_heading), 32'(act.avoidance_heading));
         field_cmp("avoidance_speed", 32'(e.avoidance_speed), 32'(act.avoidance_speed));
         field_cmp("near_range", e.near_range, act.near_range);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   avoid_scoreboard sb = new();
   bit          no_gaps = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   logic signed [31:0] cur_x = 0, cur_y = 0;

   collision_cone_heading_select uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (!reset && ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, sb.exp_q.size());
         $display("FAIL collision_cone_heading_select");
         $finish;
      end
   end

   // result side back-pressure, mostly short with a rare long hold
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if (no_gaps) begin
         rsp_stall <= 0;
      end else if ($urandom_range(0, 60) == 0) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(30, 150);
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_request(req_type r);
      int gap;
      gap = 0;
      if (!no_gaps)
         gap = ($urandom_range(0, 30) == 0) ? $urandom_range(20, 120)
                                            : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_request(r);
      if (r.cmd == CMD_NAV) begin
         cur_x = r.pos_x;
         cur_y = r.pos_y;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic apply_setting(logic [23:0] sr, logic [23:0] ad, logic [15:0] dh,
                                logic [15:0] ds);
      settle();
      csr_write(REG_SAFETY_RADIUS, {8'($urandom_range(0, 255)), sr});
      csr_write(REG_ACTIVATION, {8'($urandom_range(0, 255)), ad});
      csr_write(REG_DES_HEADING, {16'($urandom), dh});
      csr_write(REG_DES_SPEED, {16'($urandom), ds});
   endtask

   function automatic req_type make_req(logic [1:0] c, logic [3:0] s, longint x, longint y,
                                        logic [15:0] h);
      req_type r;
      r.cmd = c;
      r.slot = s;
      r.pos_x = x[31:0];
      r.pos_y = y[31:0];
      r.nav_hdg = h;
      return r;
   endfunction

   function automatic req_type random_req();
      int pick;
      longint span, ox, oy;
      logic [15:0] h;
      pick = $urandom_range(0, 99);
      span = longint'(sb.activation_distance) * 2 + 64;
      if (pick < 10) begin
         h = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
         if ($urandom_range(0, 3) == 0)
            return make_req(CMD_NAV, 4'($urandom), $signed($urandom), $signed($urandom), h);
         ox = longint'($signed(32'($urandom_range(0, 2097152)))) - 1048576;
         oy = longint'($signed(32'($urandom_range(0, 2097152)))) - 1048576;
         return make_req(CMD_NAV, 4'($urandom), ox, oy, h);
      end
      if (pick < 55) begin
         if ($urandom_range(0, 5) == 0)
            return make_req(CMD_CONTACT, 4'($urandom), $signed($urandom), $signed($urandom),
                            16'($urandom));
         ox = longint'(cur_x) + longint'($urandom_range(0, 32'(span * 2))) - span;
         oy = longint'(cur_y) + longint'($urandom_range(0, 32'(span * 2))) - span;
         return make_req(CMD_CONTACT, 4'($urandom), ox, oy, 16'($urandom));
      end
      if (pick < 95)
         return make_req(CMD_COMPUTE, 4'($urandom), $signed($urandom), $signed($urandom),
                         16'($urandom));
      return make_req(CMD_SPARE, 4'($urandom), $signed($urandom), $signed($urandom),
                      16'($urandom));
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // empty table, then distance zero, exact activation edge, cone and overflow
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_SPARE, 4'hF, -1, -1, 16'hFFFF));
      send_request(make_req(CMD_NAV, 0, 0, 0, 16'd65535));
      send_request(make_req(CMD_CONTACT, 0, 0, 0, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_CONTACT, 0, 12800, 0, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_CONTACT, 0, 0, 9000, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_CONTACT, 15, -7000, -8000, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_CONTACT, 3, -9000, 7000, 0));
      send_request(make_req(CMD_CONTACT, 4, -9000, 7000, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_NAV, 0, -64'sd2147483648, -64'sd2147483648, 16'd35999));
      for (int i = 0; i < MAX_CONTACTS; i++)
         send_request(make_req(CMD_CONTACT, 4'(i), 2147483647, 2147483647, 0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));
      send_request(make_req(CMD_NAV, 0, 2147483647, 2147483647, 16'd0));
      send_request(make_req(CMD_COMPUTE, 0, 0, 0, 0));

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_setting(24'd6400, 24'd12800, 16'd0, 16'd512);
            1: apply_setting(24'd0, 24'hFFFFFF, 16'd35999, 16'hFFFF);
            2: apply_setting(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'd0);
            3: apply_setting(24'd100, 24'd0, 16'd18000, 16'd1);
            4: apply_setting(24'($urandom_range(0, 40000)), 24'($urandom_range(0, 200000)),
                             16'($urandom), 16'($urandom));
            default: apply_setting(24'($urandom_range(0, 20000)),
                                   24'($urandom_range(20000, 300000)),
                                   16'($urandom_range(0, 35999)), 16'($urandom));
         endcase
         no_gaps = (ph % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_req());
      end
      no_gaps = 0;
      settle();
      repeat (300) @(posedge clock);

      $display("%0d compute results checked, %0d collisions, %0d on the cone edge",
               sb.results, sb.collisions, sb.cone_hits);
      if (sb.errors == 0 && sb.exp_q.size() == 0) begin
         $display("PASS collision_cone_heading_select");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.exp_q.size());
         $display("FAIL collision_cone_heading_select");
      end
      $finish;
   end
endmodule
